[src/sar_pkg.sv]
package sar_pkg;

  localparam int DATA_W        = 32;
  localparam int MAIN_DEPTH    = 32;
  localparam int PATTERN_DEPTH = 32;
  localparam int RESULT_LIMIT  = 32;

  localparam int MCNT_W = $clog2(MAIN_DEPTH + 1);
  localparam int PCNT_W = $clog2(PATTERN_DEPTH + 1);
  localparam int POS_W  = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
  localparam int SUM_W  = ((MCNT_W > PCNT_W) ? MCNT_W : PCNT_W) + 1;
  localparam int ECNT_W = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [1:0] {
    OP_MAIN = 2'd0,
    OP_PAT  = 2'd1,
    OP_RUN  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EMIT,
    S_STATUS
  } state_t;

endpackage

[src/sar_main_cell.sv]
module sar_main_cell (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic signed [sar_pkg::DATA_W-1:0]  wr_data,
  input  logic                               shift_en,
  input  logic signed [sar_pkg::DATA_W-1:0]  shift_in,
  output logic signed [sar_pkg::DATA_W-1:0]  data
);
  import sar_pkg::*;

  // one slot of the rotating main array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      data <= wr_data;
    end else if (shift_en) begin
      data <= shift_in;
    end
  end

endmodule

[src/sar_pat_cell.sv]
module sar_pat_cell (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic signed [sar_pkg::DATA_W-1:0]  wr_data,
  input  logic signed [sar_pkg::DATA_W-1:0]  main_data,
  output logic                               hit
);
  import sar_pkg::*;

  logic signed [DATA_W-1:0] pat;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat <= wr_data;
    end
  end

  // element of the current window matches this pattern slot
  assign hit = (pat == main_data);

endmodule

[src/subarray_find_and_remove.sv]
// subarray_find_and_remove
// request channel (req_valid / req_stall, fields opcode and value):
//   opcode 0 appends value to the main array, opcode 1 to the pattern array,
//   opcode 2 runs: find the first contiguous copy of the pattern in the main
//   array, drop it, emit what remains in order and clear both arrays.
//   loads into a full array and opcode 3 are taken and ignored.
// result channel (rsp_valid / rsp_stall, fields found, element,
//   element_valid, last): one item per remaining element, last set on the
//   final one; if nothing remains, a single status item with element_valid
//   low and last high.
// throughput: loads are taken every cycle while idle. a run holds req_stall
//   high while the main cell chain makes one full rotation to search and
//   one more to emit, then while a status item is loaded if one is due,
//   and for as long as the receiver stalls a pending result.
// the main array lives in a ring of cells that rotates by one each cycle of
//   a run unless a stalled result holds it; pattern cells compare against
//   the window at the head of the ring.
// reset: both arrays empty, no result pending. while rsp_stall is high with
//   a result pending the result register holds, and the ring waits if
//   the element at its head is to be emitted.
module subarray_find_and_remove (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          opcode,
  input  logic signed [sar_pkg::DATA_W-1:0]   value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                found,
  output logic signed [sar_pkg::DATA_W-1:0]   element,
  output logic                                element_valid,
  output logic                                last
);
  import sar_pkg::*;

  state_t state, state_next;

  logic [MCNT_W-1:0] main_count;
  logic [PCNT_W-1:0] pat_count;
  logic [POS_W-1:0]  pos;          // logical index held in cell 0
  logic [POS_W-1:0]  fstart;       // start of the first match
  logic              found_r;
  logic [ECNT_W-1:0] ecnt;         // results emitted so far in this run

  logic signed [DATA_W-1:0] main_q [MAIN_DEPTH];
  logic [PATTERN_DEPTH-1:0] hits;
  logic [PATTERN_DEPTH-1:0] pmask;

  // control decoded per cycle
  logic req_acc, load_main, load_pat, run_go;
  logic rotate, load_out, out_free, pos_last;
  logic keep, match, cand;
  logic [MCNT_W-1:0] rem;
  logic [ECNT_W-1:0] lim;

  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign pos_last  = (pos == POS_W'(MAIN_DEPTH - 1));

  // ---------------------------------------------------------------- cells
  genvar gi;
  generate
    for (gi = 0; gi < MAIN_DEPTH; gi++) begin : g_main
      localparam int NXT = (gi + 1) % MAIN_DEPTH;
      sar_main_cell u_cell (
        .clk      (clk),
        .wr_en    (load_main && (main_count == MCNT_W'(gi))),
        .wr_data  (value),
        .shift_en (rotate),
        .shift_in (main_q[NXT]),
        .data     (main_q[gi])
      );
    end

    for (gi = 0; gi < PATTERN_DEPTH; gi++) begin : g_pat
      logic signed [DATA_W-1:0] cmp;
      if (gi < MAIN_DEPTH) begin : g_cmp
        assign cmp = main_q[gi];
      end else begin : g_nocmp
        // window never reaches here when a match is possible
        assign cmp = '0;
      end
      sar_pat_cell u_cell (
        .clk       (clk),
        .wr_en     (load_pat && (pat_count == PCNT_W'(gi))),
        .wr_data   (value),
        .main_data (cmp),
        .hit       (hits[gi])
      );
      assign pmask[gi] = (PCNT_W'(gi) < pat_count);
    end
  endgenerate

  // whole pattern matches window starting at pos, window inside the array
  assign match = &(hits | ~pmask);
  assign cand  = (pat_count != '0) &&
                 ((SUM_W'(pos) + SUM_W'(pat_count)) <= SUM_W'(main_count));

  // elements left after removal and how many of them get emitted
  always_comb begin
    rem = found_r ? (main_count - MCNT_W'(pat_count)) : main_count;
    lim = (int'(rem) > RESULT_LIMIT) ? ECNT_W'(RESULT_LIMIT) : ECNT_W'(rem);
  end

  // element in cell 0 survives and is still within the result limit
  assign keep = (MCNT_W'(pos) < main_count) && (ecnt < lim) &&
                !(found_r && (pos >= fstart) &&
                  (SUM_W'(pos) < (SUM_W'(fstart) + SUM_W'(pat_count))));

  // ---------------------------------------------------------------- outputs
  always_comb begin
    load_main = 1'b0;
    load_pat  = 1'b0;
    run_go    = 1'b0;
    rotate    = 1'b0;
    load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          case (op_t'(opcode))
            OP_MAIN: load_main = (main_count != MCNT_W'(MAIN_DEPTH));
            OP_PAT:  load_pat  = (pat_count != PCNT_W'(PATTERN_DEPTH));
            OP_RUN:  run_go    = 1'b1;
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        rotate = 1'b1;
      end
      S_EMIT: begin
        rotate   = !keep || out_free;
        load_out = keep && out_free;
      end
      S_STATUS: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (run_go) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (pos_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (pos_last && rotate) begin
          state_next = (rem == '0) ? S_STATUS : S_IDLE;
        end
      end
      S_STATUS: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      main_count <= '0;
      pat_count  <= '0;
      pos        <= '0;
      found_r    <= 1'b0;
      ecnt       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (load_main) begin
        main_count <= main_count + MCNT_W'(1);
      end
      if (load_pat) begin
        pat_count <= pat_count + PCNT_W'(1);
      end

      if (run_go) begin
        found_r <= 1'b0;
        ecnt    <= '0;
      end

      if (rotate) begin
        pos <= pos_last ? '0 : (pos + POS_W'(1));
      end

      // first match only
      if (state == S_SEARCH && !found_r && cand && match) begin
        found_r <= 1'b1;
      end

      if (state == S_EMIT && load_out) begin
        ecnt <= ecnt + ECNT_W'(1);
      end

      // run finished: both arrays empty
      if (state != S_IDLE && state_next == S_IDLE) begin
        main_count <= '0;
        pat_count  <= '0;
      end

      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_SEARCH && !found_r && cand && match) begin
      fstart <= pos;
    end
    if (load_out) begin
      found <= found_r;
      if (state == S_EMIT) begin
        element       <= main_q[0];
        element_valid <= 1'b1;
        last          <= ((ecnt + ECNT_W'(1)) == lim);
      end else begin
        element       <= '0;
        element_valid <= 1'b0;
        last          <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // ring is back home whenever loads can be taken
  a_home_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (pos == '0))
    else $error("main ring not aligned in idle");

  // a run always leaves both arrays empty
  a_cleared_after_run: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != S_IDLE && state == S_IDLE) |->
      (main_count == '0 && pat_count == '0))
    else $error("arrays not cleared after run");

  // recorded match lies inside the main array
  a_match_in_range: assert property (@(posedge clk) disable iff (rst)
    (found_r && state != S_IDLE) |->
      ((SUM_W'(fstart) + SUM_W'(pat_count)) <= SUM_W'(main_count)))
    else $error("match outside main array");

  // never emit more than the remaining element count
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (ecnt <= lim))
    else $error("too many results emitted");

  // status item only when nothing remains
  a_status_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_STATUS) |-> (rem == '0))
    else $error("status item with elements left");
`endif

endmodule
